[sv/rte_pkg.sv]
// Package for the retransmit-timeout estimator: payload structs, operation
// and register codes, reset constants and the seconds reciprocal.
// No dependencies.
package rte_pkg;

  localparam int FRACTION_BITS_DEF = 8;

  localparam int MEAS_W  = 32;
  localparam int MS24_W  = 24;
  localparam int SEC_W   = 23;
  localparam int CNT_W   = 8;
  localparam int OP_W    = 3;
  localparam int CIDX_W  = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_RESET      = 3'd0;
  localparam logic [OP_W-1:0] OP_NEW_PACKET = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd2;
  localparam logic [OP_W-1:0] OP_MEASURE    = 3'd3;
  localparam logic [OP_W-1:0] OP_TIMEOUT    = 3'd4;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MIN_RTO     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_RTO     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MAX_RETRANS = 2'd2;

  localparam logic [MS24_W-1:0] MIN_RTO_RST     = 24'd2000;
  localparam logic [MS24_W-1:0] MAX_RTO_RST     = 24'd60000;
  localparam logic [CNT_W-1:0]  MAX_RETRANS_RST = 8'd3;

  localparam int RESET_DEV_MS = 750;
  localparam int RESET_RTO_MS = 3000;

  // seconds = (ms + 500) / 1000 = ((ms + 500) >> 3) / 125, the last done as
  // a multiply by ceil(2^37 / 125), exact for 30-bit operands
  localparam int HALF_SEC_MS  = 500;
  localparam int QUOT_IN_W    = 30;
  localparam int RECIP_W      = 31;
  localparam int RECIP_SHIFT  = 37;
  localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [MEAS_W-1:0] measured_ms;
  } rte_in_t;

  typedef struct packed {
    logic [SEC_W-1:0] rto_seconds;
    logic             give_up;
    logic [CNT_W-1:0] retransmit_count;
  } rte_out_t;

  typedef struct packed {
    logic [MS24_W-1:0] min_rto_ms;
    logic [MS24_W-1:0] max_rto_ms;
    logic [CNT_W-1:0]  max_retransmits;
  } rte_cfg_t;

  // result of one update, timeout in whole ms (fraction dropped)
  typedef struct packed {
    logic [MEAS_W-1:0] rto_ms;
    logic              give_up;
    logic [CNT_W-1:0]  count;
  } rte_stat_t;

endpackage

[sv/rte_update.sv]
// Estimator state and update logic: smoothed RTT, deviation, timeout and
// retransmit count, with a registered result stage.
// Depends on rte_pkg.
module rte_update import rte_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rte_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  rte_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rte_stat_t out_stat
);

  localparam int RW = MEAS_W + FRACTION_BITS;  // timeout / deviation
  localparam int SW = RW + 1;                  // smoothed RTT, signed
  localparam int XW = RW + 2;                  // signed differences
  localparam int AW = RW + 3;                  // srtt + 4*dev

  localparam logic [RW-1:0] DEV_RST = RW'(RESET_DEV_MS) << FRACTION_BITS;
  localparam logic [RW-1:0] TO_RST  = RW'(RESET_RTO_MS) << FRACTION_BITS;

  logic signed [SW-1:0] srtt_r, srtt_nxt;
  logic [RW-1:0]        dev_r, dev_nxt;
  logic [RW-1:0]        to_r, to_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 valid_r;
  rte_stat_t            stat_r, stat_nxt;

  logic [RW-1:0]        meas_w;
  logic signed [XW-1:0] srtt_ext_w, delta_w, delta_neg_w, srtt_sum_w;
  logic [RW-1:0]        mag_w;
  logic signed [XW-1:0] ddiff_w, dev_sum_w;
  logic [RW-1:0]        srtt_new_w, dev_new_w;
  logic [AW-1:0]        rto_raw_w, lo_w, hi_w;
  logic [RW-1:0]        rto_clamp_w;
  logic [CNT_W:0]       cnt_inc_w;
  logic                 give_w;
  logic                 take_w;

  assign in_ready = !valid_r || out_ready;
  assign take_w   = in_valid && in_ready;

  // measurement update
  assign meas_w      = {in_data.measured_ms, {FRACTION_BITS{1'b0}}};
  assign srtt_ext_w  = {srtt_r[SW-1], srtt_r};
  assign delta_w     = $signed({2'b00, meas_w}) - srtt_ext_w;
  assign delta_neg_w = -delta_w;
  assign mag_w       = delta_w[XW-1] ? delta_neg_w[RW-1:0] : delta_w[RW-1:0];
  assign srtt_sum_w  = srtt_ext_w + (delta_w >>> 3);
  assign ddiff_w     = $signed({2'b00, mag_w}) - $signed({2'b00, dev_r});
  assign dev_sum_w   = $signed({2'b00, dev_r}) + (ddiff_w >>> 2);
  assign srtt_new_w  = srtt_sum_w[RW-1:0];
  assign dev_new_w   = dev_sum_w[RW-1:0];

  // one clamp serves both estimator reset and measurement
  assign rto_raw_w = (in_data.operation == OP_RESET) ?
                     ({3'b000, DEV_RST} << 2) :
                     ({3'b000, srtt_new_w} + ({3'b000, dev_new_w} << 2));
  assign lo_w = AW'({cfg.min_rto_ms, {FRACTION_BITS{1'b0}}});
  assign hi_w = AW'({cfg.max_rto_ms, {FRACTION_BITS{1'b0}}});

  always_comb begin
    if (rto_raw_w < lo_w) begin
      rto_clamp_w = lo_w[RW-1:0];
    end else if (rto_raw_w > hi_w) begin
      rto_clamp_w = hi_w[RW-1:0];
    end else begin
      rto_clamp_w = rto_raw_w[RW-1:0];
    end
  end

  assign cnt_inc_w = {1'b0, cnt_r} + 1'b1;

  always_comb begin
    srtt_nxt = srtt_r;
    dev_nxt  = dev_r;
    to_nxt   = to_r;
    cnt_nxt  = cnt_r;
    give_w   = 1'b0;
    case (in_data.operation)
      OP_RESET: begin
        srtt_nxt = '0;
        dev_nxt  = DEV_RST;
        to_nxt   = rto_clamp_w;
      end
      OP_NEW_PACKET: begin
        cnt_nxt = '0;
      end
      OP_MEASURE: begin
        srtt_nxt = srtt_sum_w[SW-1:0];
        dev_nxt  = dev_new_w;
        to_nxt   = rto_clamp_w;
      end
      OP_TIMEOUT: begin
        // double, saturate at the top of the register
        to_nxt  = to_r[RW-1] ? {RW{1'b1}} : {to_r[RW-2:0], 1'b0};
        give_w  = cnt_inc_w > {1'b0, cfg.max_retransmits};
        cnt_nxt = cnt_inc_w[CNT_W] ? {CNT_W{1'b1}} : cnt_inc_w[CNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_nxt.rto_ms  = to_nxt[RW-1:FRACTION_BITS];
    stat_nxt.give_up = give_w;
    stat_nxt.count   = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r  <= '0;
      dev_r   <= DEV_RST;
      to_r    <= TO_RST;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (take_w) begin
        srtt_r <= srtt_nxt;
        dev_r  <= dev_nxt;
        to_r   <= to_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (in_ready) begin
        valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_w) begin
      stat_r <= stat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stat  = stat_r;

endmodule

[sv/rte_seconds.sv]
// Output stage: converts the timeout in ms to whole seconds, rounded half
// up, by a reciprocal multiply into the result register. Depends on rte_pkg.
module rte_seconds import rte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rte_stat_t in_stat,
  output logic      out_valid,
  input  logic      out_ready,
  output rte_out_t  out_data
);

  localparam int PW = QUOT_IN_W + RECIP_W;

  logic [MEAS_W:0]      rounded_w;
  logic [QUOT_IN_W-1:0] quot_in_w;
  logic [PW-1:0]        prod_w;
  logic                 valid_r;
  rte_out_t             data_r;

  assign in_ready  = !valid_r || out_ready;
  assign rounded_w = {1'b0, in_stat.rto_ms} + (MEAS_W+1)'(HALF_SEC_MS);
  assign quot_in_w = rounded_w[MEAS_W:3];
  assign prod_w    = PW'(quot_in_w) * PW'(RECIP_125);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r.rto_seconds      <= prod_w[RECIP_SHIFT+SEC_W-1:RECIP_SHIFT];
      data_r.give_up          <= in_stat.give_up;
      data_r.retransmit_count <= in_stat.count;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[sv/rtt_estimator_retransmit_timer.sv]
// Retransmit-timeout estimator, top level: configuration registers, input
// register, update stage and seconds stage. Depends on rte_pkg, rte_update,
// rte_seconds.
//
// Requests arrive on in_valid/in_ready/in_data and each gives exactly one
// result on out_valid/out_ready/out_data, in order. Operations: estimator
// reset, new packet (clears the retransmit count), query, RTT measurement
// (srtt += delta/8, dev += (|delta|-dev)/4, timeout = clamp(srtt + 4*dev))
// and timeout (doubles the timeout, counts a retransmission, flags give-up).
// Three register stages: input register, state update into the result
// register, then the ms-to-seconds multiply into the output register.
// A request passes the input, result and output registers; out_valid rises
// at the output register. One request is taken every cycle while out_ready
// is high; the multiplier and the update adders each sit in their own stage.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes the minimum
// and maximum timeout in ms and the retransmit limit, one per cycle.
// Synchronous reset empties the pipeline and loads srtt 0, deviation 750 ms,
// timeout 3000 ms, count 0 and the default registers. When the receiver
// stalls, each full stage holds its request and in_ready drops once all
// three stages are full.
module rtt_estimator_retransmit_timer import rte_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rte_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rte_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [MS24_W-1:0] cfg_wdata
);

  rte_cfg_t  cfg_r;
  logic      in_valid_r;
  rte_in_t   in_data_r;
  logic      upd_ready;
  logic      upd_valid;
  rte_stat_t upd_stat;
  logic      sec_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_rto_ms      <= MIN_RTO_RST;
      cfg_r.max_rto_ms      <= MAX_RTO_RST;
      cfg_r.max_retransmits <= MAX_RETRANS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_RTO:     cfg_r.min_rto_ms      <= cfg_wdata;
        CFG_MAX_RTO:     cfg_r.max_rto_ms      <= cfg_wdata;
        CFG_MAX_RETRANS: cfg_r.max_retransmits <= cfg_wdata[CNT_W-1:0];
        default: begin
          // no register here: drop the write
        end
      endcase
    end
  end

  assign in_ready = !in_valid_r || upd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  rte_update #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid_r),
    .in_ready  (upd_ready),
    .in_data   (in_data_r),
    .out_valid (upd_valid),
    .out_ready (sec_ready),
    .out_stat  (upd_stat)
  );

  rte_seconds u_seconds (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (upd_valid),
    .in_ready  (sec_ready),
    .in_stat   (upd_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
